// ===== rtl/core/mice_pkg.sv =====
package mice_pkg;

    localparam logic [7:0] C_NIB_MASK  = 8'hF0;
    localparam logic [7:0] C_NIB_FIVE  = 8'h50;
    localparam logic [7:0] C_NIB_THREE = 8'h30;

    // longitude degree offset ranges
    localparam logic [7:0] C_DEG_A_LO  = 8'h76;
    localparam logic [7:0] C_DEG_A_HI  = 8'h7F;
    localparam logic [7:0] C_DEG_B_LO  = 8'h6C;
    localparam logic [7:0] C_DEG_B_HI  = 8'h75;
    localparam logic [7:0] C_DEG_C_LO  = 8'h26;
    localparam logic [7:0] C_DEG_C_HI  = 8'h6B;

    // longitude minute offset ranges
    localparam logic [7:0] C_MIN_A_LO  = 8'h58;
    localparam logic [7:0] C_MIN_A_HI  = 8'h61;
    localparam logic [7:0] C_MIN_B_LO  = 8'h26;
    localparam logic [7:0] C_MIN_B_HI  = 8'h57;

    localparam logic [7:0] C_FRAC_LO   = 8'h1C;
    localparam logic [7:0] C_FRAC_HI   = 8'h7F;

    // floor(x/5) == (x*205)>>10 for x < 1024
    localparam logic [16:0] C_RECIP5   = 17'd205;

    typedef struct packed {
        logic       ok;
        logic [7:0] radio;
        logic [6:0] lat_deg;
        logic [5:0] lat_min;
        logic [6:0] lat_hun;
        logic       lat_south;
        logic [7:0] lon_deg;
        logic [5:0] lon_min;
        logic [6:0] lon_hun;
        logic       lon_west;
        logic [8:0] lat_x3;     // 3 * hundredths
        logic [8:0] lon_x3;
    } t_dec;

    function automatic logic hi_ok(input logic [7:0] b);
        return ((b & C_NIB_MASK) == C_NIB_FIVE) || ((b & C_NIB_MASK) == C_NIB_THREE);
    endfunction

    function automatic logic in_rng(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

// ===== rtl/core/mic_e_position_decode.sv =====
// Mic-E position record decoder, three-stage pipeline.
// Records pass through the stage registers r_d1 and r_d2 and then the output
// registers, which drive o_valid and the result; a stall holds them in place.
// Throughput: one record per cycle unless stalled by i_ready; stages: field decode,
// reciprocal multiply for seconds, remainder round and output mask.
// Reset (synchronous, active low) clears the stage valid bits only.
module mic_e_position_decode (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_radio_code,
    input  logic [7:0] i_lat_deg_tens_byte,
    input  logic [7:0] i_lat_deg_units_byte,
    input  logic [7:0] i_lat_min_tens_byte,
    input  logic [7:0] i_lat_min_units_byte,
    input  logic [7:0] i_lat_frac_tens_byte,
    input  logic [7:0] i_lat_frac_units_byte,
    input  logic [7:0] i_lon_deg_byte,
    input  logic [7:0] i_lon_min_byte,
    input  logic [7:0] i_lon_frac_byte,
    input  logic       i_sender_unknown,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_valid_res,
    output logic [7:0] o_radio_model_out,
    output logic [6:0] o_lat_deg,
    output logic [5:0] o_lat_min,
    output logic [6:0] o_lat_min_hundredths,
    output logic       o_lat_south,
    output logic [5:0] o_lat_sec,
    output logic [7:0] o_lon_deg,
    output logic [5:0] o_lon_min,
    output logic [6:0] o_lon_min_hundredths,
    output logic       o_lon_west,
    output logic [5:0] o_lon_sec
);
    import mice_pkg::*;

    t_dec        dec;
    logic        en1, en2, en3;

    logic        r_v1, r_v2, r_v3;
    t_dec        r_d1, r_d2;
    logic [6:0]  r_lat_q, r_lon_q;

    logic [16:0] lat_prod, lon_prod;
    logic [8:0]  lat_r, lon_r;
    logic [6:0]  lat_sec_w, lon_sec_w;

    logic        r_res;
    logic [7:0]  r_radio;
    logic [6:0]  r_lat_deg, r_lat_hun, r_lon_hun;
    logic [5:0]  r_lat_min, r_lat_sec, r_lon_min, r_lon_sec;
    logic [7:0]  r_lon_deg;
    logic        r_lat_south, r_lon_west;

    mice_check u_check (
        .i_radio_code          (i_radio_code),
        .i_lat_deg_tens_byte   (i_lat_deg_tens_byte),
        .i_lat_deg_units_byte  (i_lat_deg_units_byte),
        .i_lat_min_tens_byte   (i_lat_min_tens_byte),
        .i_lat_min_units_byte  (i_lat_min_units_byte),
        .i_lat_frac_tens_byte  (i_lat_frac_tens_byte),
        .i_lat_frac_units_byte (i_lat_frac_units_byte),
        .i_lon_deg_byte        (i_lon_deg_byte),
        .i_lon_min_byte        (i_lon_min_byte),
        .i_lon_frac_byte       (i_lon_frac_byte),
        .i_sender_unknown      (i_sender_unknown),
        .o_dec                 (dec)
    );

    // a stage loads when empty or when the one after it moves
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: decoded fields
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_d1 <= dec;
        end
    end

    // stage 2: q = floor(3h/5)
    assign lat_prod = {8'b0, r_d1.lat_x3} * C_RECIP5;
    assign lon_prod = {8'b0, r_d1.lon_x3} * C_RECIP5;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_d2    <= r_d1;
            r_lat_q <= lat_prod[16:10];
            r_lon_q <= lon_prod[16:10];
        end
    end

    // stage 3: round up when 3h mod 5 >= 3 (i.e. 60h mod 100 >= 50)
    always_comb begin
        lat_r     = r_d2.lat_x3 - (({2'b0, r_lat_q} << 2) + {2'b0, r_lat_q});
        lon_r     = r_d2.lon_x3 - (({2'b0, r_lon_q} << 2) + {2'b0, r_lon_q});
        lat_sec_w = r_lat_q + {6'b0, (lat_r[2:0] >= 3'd3)};
        lon_sec_w = r_lon_q + {6'b0, (lon_r[2:0] >= 3'd3)};
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_res       <= r_d2.ok;
            r_radio     <= r_d2.ok ? r_d2.radio     : 8'd0;
            r_lat_deg   <= r_d2.ok ? r_d2.lat_deg   : 7'd0;
            r_lat_min   <= r_d2.ok ? r_d2.lat_min   : 6'd0;
            r_lat_hun   <= r_d2.ok ? r_d2.lat_hun   : 7'd0;
            r_lat_south <= r_d2.ok && r_d2.lat_south;
            r_lat_sec   <= r_d2.ok ? lat_sec_w[5:0] : 6'd0;
            r_lon_deg   <= r_d2.ok ? r_d2.lon_deg   : 8'd0;
            r_lon_min   <= r_d2.ok ? r_d2.lon_min   : 6'd0;
            r_lon_hun   <= r_d2.ok ? r_d2.lon_hun   : 7'd0;
            r_lon_west  <= r_d2.ok && r_d2.lon_west;
            r_lon_sec   <= r_d2.ok ? lon_sec_w[5:0] : 6'd0;
        end
    end

    assign o_valid              = r_v3;
    assign o_valid_res          = r_res;
    assign o_radio_model_out    = r_radio;
    assign o_lat_deg            = r_lat_deg;
    assign o_lat_min            = r_lat_min;
    assign o_lat_min_hundredths = r_lat_hun;
    assign o_lat_south          = r_lat_south;
    assign o_lat_sec            = r_lat_sec;
    assign o_lon_deg            = r_lon_deg;
    assign o_lon_min            = r_lon_min;
    assign o_lon_min_hundredths = r_lon_hun;
    assign o_lon_west           = r_lon_west;
    assign o_lon_sec            = r_lon_sec;

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_radio_model_out == 8'd0 && o_lat_sec == 6'd0
                                       && o_lon_deg == 8'd0 && !o_lon_west))
        else $error("rejected record carries nonzero fields");

    a_lat_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_lat_deg <= 7'd89 && o_lat_min <= 6'd59
                                      && o_lat_min_hundredths <= 7'd99 && o_lat_sec <= 6'd59))
        else $error("latitude field out of range");

    a_lon_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_lon_deg <= 8'd179 && o_lon_min <= 6'd59
                                      && o_lon_min_hundredths <= 7'd99 && o_lon_sec <= 6'd59))
        else $error("longitude field out of range");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> r_v2)
        else $error("pipeline stage lost an item under stall");

endmodule

// ===== rtl/core/mice_check.sv =====
module mice_check (
    input  logic [7:0]    i_radio_code,
    input  logic [7:0]    i_lat_deg_tens_byte,
    input  logic [7:0]    i_lat_deg_units_byte,
    input  logic [7:0]    i_lat_min_tens_byte,
    input  logic [7:0]    i_lat_min_units_byte,
    input  logic [7:0]    i_lat_frac_tens_byte,
    input  logic [7:0]    i_lat_frac_units_byte,
    input  logic [7:0]    i_lon_deg_byte,
    input  logic [7:0]    i_lon_min_byte,
    input  logic [7:0]    i_lon_frac_byte,
    input  logic          i_sender_unknown,
    output mice_pkg::t_dec o_dec
);
    import mice_pkg::*;

    logic [3:0] dt, du, mt, mu, ft, fu;
    logic [7:0] lat_deg_w, lat_min_w, lat_fr_w;
    logic [7:0] lon_deg_w, lon_min_w, lon_fr_w;
    logic       nib_ok, lat_ok, deg_ok, min_ok, fr_ok;

    always_comb begin
        dt = i_lat_deg_tens_byte[3:0];
        du = i_lat_deg_units_byte[3:0];
        mt = i_lat_min_tens_byte[3:0];
        mu = i_lat_min_units_byte[3:0];
        ft = i_lat_frac_tens_byte[3:0];
        fu = i_lat_frac_units_byte[3:0];

        lat_deg_w = ({4'b0, dt} * 8'd10) + {4'b0, du};
        lat_min_w = ({4'b0, mt} * 8'd10) + {4'b0, mu};
        lat_fr_w  = ({4'b0, ft} * 8'd10) + {4'b0, fu};

        nib_ok = hi_ok(i_lat_deg_tens_byte) && hi_ok(i_lat_deg_units_byte)
              && hi_ok(i_lat_min_tens_byte) && hi_ok(i_lat_min_units_byte)
              && hi_ok(i_lat_frac_tens_byte) && hi_ok(i_lat_frac_units_byte);

        // hundredths units may be ten
        lat_ok = (dt <= 4'd9) && (du <= 4'd9) && (lat_deg_w <= 8'd89)
              && (mt <= 4'd9) && (mu <= 4'd9) && (lat_min_w <= 8'd59)
              && (ft <= 4'd9) && (fu <= 4'd10) && (lat_fr_w <= 8'd99);

        lon_deg_w = 8'd0;
        deg_ok    = 1'b1;
        if ((i_lat_frac_tens_byte & C_NIB_MASK) == C_NIB_FIVE) begin
            if (in_rng(i_lon_deg_byte, C_DEG_A_LO, C_DEG_A_HI)) begin
                lon_deg_w = i_lon_deg_byte - C_DEG_A_LO;
            end else if (in_rng(i_lon_deg_byte, C_DEG_B_LO, C_DEG_B_HI)) begin
                lon_deg_w = 8'd100 + (i_lon_deg_byte - C_DEG_B_LO);
            end else if (in_rng(i_lon_deg_byte, C_DEG_C_LO, C_DEG_C_HI)) begin
                lon_deg_w = 8'd110 + (i_lon_deg_byte - C_DEG_C_LO);
            end else begin
                deg_ok = 1'b0;
            end
        end else begin
            if (in_rng(i_lon_deg_byte, C_DEG_C_LO, C_DEG_A_HI)) begin
                lon_deg_w = 8'd10 + (i_lon_deg_byte - C_DEG_C_LO);
            end else begin
                deg_ok = 1'b0;
            end
        end

        lon_min_w = 8'd0;
        min_ok    = 1'b1;
        if (in_rng(i_lon_min_byte, C_MIN_A_LO, C_MIN_A_HI)) begin
            lon_min_w = i_lon_min_byte - C_MIN_A_LO;
        end else if (in_rng(i_lon_min_byte, C_MIN_B_LO, C_MIN_B_HI)) begin
            lon_min_w = 8'd10 + (i_lon_min_byte - C_MIN_B_LO);
        end else begin
            min_ok = 1'b0;
        end

        fr_ok    = in_rng(i_lon_frac_byte, C_FRAC_LO, C_FRAC_HI);
        lon_fr_w = fr_ok ? (i_lon_frac_byte - C_FRAC_LO) : 8'd0;

        o_dec.ok        = !i_sender_unknown && nib_ok && lat_ok && deg_ok && min_ok && fr_ok;
        o_dec.radio     = i_radio_code;
        o_dec.lat_deg   = lat_deg_w[6:0];
        o_dec.lat_min   = lat_min_w[5:0];
        o_dec.lat_hun   = lat_fr_w[6:0];
        o_dec.lat_south = (i_lat_min_units_byte & C_NIB_MASK) == C_NIB_THREE;
        o_dec.lon_deg   = lon_deg_w;
        o_dec.lon_min   = lon_min_w[5:0];
        o_dec.lon_hun   = lon_fr_w[6:0];
        o_dec.lon_west  = (i_lat_frac_units_byte & C_NIB_MASK) == C_NIB_FIVE;
        o_dec.lat_x3    = ({2'b0, lat_fr_w[6:0]} << 1) + {2'b0, lat_fr_w[6:0]};
        o_dec.lon_x3    = ({2'b0, lon_fr_w[6:0]} << 1) + {2'b0, lon_fr_w[6:0]};
    end

endmodule
